// File: design/rpba_pkg.sv
package rpba_pkg;

	localparam int SIZE_W      = 5;
	localparam int TAG_W       = 5;
	localparam int BLK_W       = 5;
	localparam int NEXT_W      = 6;
	localparam int PROBE_W     = 7;
	localparam int SEED_W      = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int LFSR_W      = 16;
	localparam int CHAIN_MAX   = 24;
	localparam int CHAIN_AW    = $clog2(CHAIN_MAX);
	localparam int MOD_STEPS   = 3;
	localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

	localparam logic [LFSR_W-1:0]  LFSR_TAPS    = 16'hB400;
	localparam logic [PROBE_W-1:0] PROBES_RESET = 7'd75;
	localparam logic [SEED_W-1:0]  SEED_RESET   = 16'd1;
	localparam logic [NEXT_W-1:0]  NONE_LINK    = 6'h3F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PROBES  = 1'b0,
		REG_RANDOM_SEED = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic draw;
		logic mod_step;
		logic check;
		logic rd_first;
		logic load_cur;
		logic emit;
		logic fail;
	} rpba_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic in_bad;
		logic probe_out;
		logic mod_last;
		logic cand_free;
		logic chain_done;
		logic out_free;
		logic emit_last;
	} rpba_stat_t;

	// Galois step, shifting right
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] r;
		r = s >> 1;
		if (s[0]) begin
			r = r ^ LFSR_TAPS;
		end
		return r;
	endfunction

endpackage

// File: design/random_probe_block_allocator.sv
// Random-probe block allocator. Blocks 0 to RESERVED_BLOCKS-1 are reserved at
// reset; each request (file_size, owner_tag) takes file_size blocks from the
// free area by drawing candidates from a 16-bit LFSR, one draw per probe, with
// up to max_probes draws per block. On success one transaction per block comes
// out in chain order, next_index holding the following block or -1 on the
// final one; on failure (probe budget spent, or a size above the free area or
// above 24) a single transaction with failed set comes out and nothing is
// committed. A zero size is consumed without any result. Blocks are never
// freed. Each probe is a draw, three remainder steps by reciprocal multiply
// and a candidate check; an oversized request fails without probing. One
// request is worked at a time; the next is taken as soon as its last result
// is in the output register. Write configuration only while idle; a seed
// write reloads the LFSR (0 loads 1).
module random_probe_block_allocator #(
	parameter int TOTAL_BLOCKS_P  = 32,
	parameter int RESERVED_BLOCKS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: index 0 max_probes, index 1 random_seed
	input  logic                               cfg_wr_en,
	input  logic [rpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpba_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rpba_pkg::SIZE_W-1:0]        file_size,
	input  logic [rpba_pkg::TAG_W-1:0]         owner_tag,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rpba_pkg::BLK_W-1:0]         block_index,
	output logic signed [rpba_pkg::NEXT_W-1:0] next_index,
	output logic                               failed,
	output logic                               last
);
	import rpba_pkg::*;

	rpba_cmd_t  cmd;
	rpba_stat_t stat;

	// sequencer: accept, probe loop, commit and emit
	rpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// generator, remainder unit, block maps, chain store and output register
	rpba_dp #(
		.TOTAL_BLOCKS_P  (TOTAL_BLOCKS_P),
		.RESERVED_BLOCKS (RESERVED_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.file_size   (file_size),
		.owner_tag   (owner_tag),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.block_index (block_index),
		.next_index  (next_index),
		.failed      (failed),
		.last        (last)
	);

endmodule

// File: design/rpba_ctrl.sv
module rpba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpba_pkg::rpba_stat_t stat,
	output rpba_pkg::rpba_cmd_t  cmd
);
	import rpba_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_DRAW  = 9'b000000100,
		ST_MOD   = 9'b000001000,
		ST_CHECK = 9'b000010000,
		ST_RD0   = 9'b000100000,
		ST_RD1   = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_FAIL  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.in_zero) begin
						state_nxt = ST_IDLE;
					end else if (stat.in_bad) begin
						state_nxt = ST_FAIL;
					end else begin
						state_nxt = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_nxt = ST_DRAW;
			end
			ST_DRAW: begin
				if (stat.probe_out) begin
					state_nxt = ST_FAIL;
				end else begin
					cmd.draw  = 1'b1;
					state_nxt = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.cand_free && stat.chain_done) begin
					state_nxt = ST_RD0;
				end else begin
					state_nxt = ST_DRAW;
				end
			end
			ST_RD0: begin
				cmd.rd_first = 1'b1;
				state_nxt    = ST_RD1;
			end
			ST_RD1: begin
				cmd.load_cur = 1'b1;
				state_nxt    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_FAIL: begin
				if (stat.out_free) begin
					cmd.fail  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_draw_within_budget: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |-> !stat.probe_out)
		else $error("draw issued with probe budget spent");

endmodule

// File: design/rpba_dp.sv
module rpba_dp #(
	parameter int TOTAL_BLOCKS_P  = 32,
	parameter int RESERVED_BLOCKS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [rpba_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rpba_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [rpba_pkg::SIZE_W-1:0]             file_size,
	input  logic [rpba_pkg::TAG_W-1:0]              owner_tag,
	input  rpba_pkg::rpba_cmd_t                     cmd,
	output rpba_pkg::rpba_stat_t                    stat,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [rpba_pkg::BLK_W-1:0]              block_index,
	output logic signed [rpba_pkg::NEXT_W-1:0]      next_index,
	output logic                                    failed,
	output logic                                    last
);
	import rpba_pkg::*;

	localparam int FREE     = TOTAL_BLOCKS_P - RESERVED_BLOCKS;
	localparam int FREE_C   = (FREE > 0) ? FREE : 1;
	localparam int IDX_W    = $clog2(TOTAL_BLOCKS_P);
	localparam int RW       = $clog2(FREE_C) + 1;
	localparam logic [RW-1:0] FREE_R = RW'(FREE_C);
	// reciprocal of the free-area size, exact enough to land within one of the quotient
	localparam int RECIP_SH = LFSR_W + RW;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = LFSR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(FREE_C));

	// configuration and generator
	logic [PROBE_W-1:0] max_probes_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_nxt;

	// request context and counters
	logic [SIZE_W-1:0]   size_q;
	logic [TAG_W-1:0]    tag_q;
	logic [PROBE_W-1:0]  probe_cnt_q;
	logic [CHAIN_AW-1:0] chain_cnt_q;
	logic [CHAIN_AW-1:0] emit_cnt_q;

	// remainder unit
	logic [LFSR_W-1:0]    mod_x_q;
	logic [LFSR_W-1:0]    quot_q;
	logic [RW-1:0]        rest_q;
	logic [RW-1:0]        rem_q;
	logic [PROD_W-1:0]    prod;
	logic [LFSR_W-1:0]    quot_nxt;
	logic [LFSR_W-1:0]    qd;
	logic [RW-1:0]        rest_nxt;
	logic [RW-1:0]        rem_fix;
	logic [MOD_CNT_W-1:0] mod_cnt_q;

	// block maps and stores
	logic [TOTAL_BLOCKS_P-1:0] alloc_q;
	logic [TOTAL_BLOCKS_P-1:0] chosen_q;
	logic [IDX_W-1:0]          chain_mem [CHAIN_MAX];
	logic [TAG_W-1:0]          owner_mem [TOTAL_BLOCKS_P];
	logic [IDX_W:0]            link_mem  [TOTAL_BLOCKS_P];
	logic [IDX_W-1:0]          rd_data_q;
	logic [IDX_W-1:0]          cur_q;

	logic [IDX_W-1:0]    cand;
	logic                cand_ok;
	logic                rd_en;
	logic [CHAIN_AW:0]   rd_ptr;
	logic [CHAIN_AW-1:0] rd_addr;
	logic [15:0]         cur_w;
	logic [15:0]         nxt_w;
	logic                take_next;

	// output register
	logic                     out_valid_q;
	logic [BLK_W-1:0]         block_index_q;
	logic [NEXT_W-1:0]        next_index_q;
	logic                     failed_q;
	logic                     last_q;

	assign lfsr_nxt = lfsr_step(lfsr_q);

	// remainder in three steps: estimate the quotient, take the rest, then
	// drop one more free-area size if the estimate came out one low
	assign prod     = PROD_W'(mod_x_q) * PROD_W'(RECIP);
	assign quot_nxt = prod[RECIP_SH +: LFSR_W];
	assign qd       = LFSR_W'(32'(quot_q) * 32'(FREE_C));
	assign rest_nxt = RW'(mod_x_q - qd);
	assign rem_fix  = (rest_q >= FREE_R) ? (rest_q - FREE_R) : rest_q;

	assign cand    = IDX_W'(32'(RESERVED_BLOCKS) + 32'(rem_q));
	assign cand_ok = !alloc_q[cand] && !chosen_q[cand];

	assign stat.in_zero    = (file_size == '0);
	assign stat.in_bad     = (FREE <= 0) || (int'(file_size) > FREE)
		|| (int'(file_size) > CHAIN_MAX);
	assign stat.probe_out  = (probe_cnt_q >= max_probes_q);
	assign stat.mod_last   = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
	assign stat.cand_free  = cand_ok;
	assign stat.chain_done = ({1'b0, chain_cnt_q} == ({1'b0, size_q} - 6'd1));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.emit_last  = (({1'b0, emit_cnt_q} + 6'd1) == {1'b0, size_q});

	assign take_next = cmd.emit && !stat.emit_last;

	// chain store read: stay one entry ahead of the block being emitted
	always_comb begin
		rd_en  = 1'b0;
		rd_ptr = '0;
		if (cmd.rd_first) begin
			rd_en = 1'b1;
		end else if (cmd.load_cur) begin
			rd_ptr = {1'b0, emit_cnt_q} + 6'd1;
			rd_en  = (rd_ptr < {1'b0, size_q});
		end else if (take_next) begin
			rd_ptr = {1'b0, emit_cnt_q} + 6'd2;
			rd_en  = (rd_ptr < {1'b0, size_q});
		end
		rd_addr = rd_ptr[CHAIN_AW-1:0];
	end

	assign cur_w = 16'(cur_q);
	assign nxt_w = 16'(rd_data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_probes_q <= PROBES_RESET;
			lfsr_q       <= SEED_RESET;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_PROBES: begin
						max_probes_q <= cfg_data[PROBE_W-1:0];
					end
					REG_RANDOM_SEED: begin
						lfsr_q <= (cfg_data[SEED_W-1:0] == '0) ? SEED_RESET
							: cfg_data[SEED_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.draw) begin
				lfsr_q <= lfsr_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_cnt_q <= '0;
			chain_cnt_q <= '0;
			emit_cnt_q  <= '0;
			mod_cnt_q   <= '0;
			chosen_q    <= '0;
			for (int b = 0; b < TOTAL_BLOCKS_P; b++) begin
				alloc_q[b] <= (b < RESERVED_BLOCKS);
			end
		end else begin
			if (cmd.start) begin
				chosen_q    <= '0;
				chain_cnt_q <= '0;
				probe_cnt_q <= '0;
			end
			if (cmd.draw) begin
				probe_cnt_q <= probe_cnt_q + 7'd1;
				mod_cnt_q   <= '0;
			end
			if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
			end
			if (cmd.check && cand_ok) begin
				chosen_q[cand] <= 1'b1;
				chain_cnt_q    <= chain_cnt_q + CHAIN_AW'(1);
				probe_cnt_q    <= '0;
			end
			if (cmd.rd_first) begin
				emit_cnt_q <= '0;
			end
			if (take_next) begin
				emit_cnt_q <= emit_cnt_q + CHAIN_AW'(1);
			end
			if (cmd.emit) begin
				alloc_q[cur_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			size_q <= file_size;
			tag_q  <= owner_tag;
		end
		if (cmd.draw) begin
			mod_x_q <= lfsr_nxt;
		end
		if (cmd.mod_step && (mod_cnt_q == MOD_CNT_W'(0))) begin
			quot_q <= quot_nxt;
		end
		if (cmd.mod_step && (mod_cnt_q == MOD_CNT_W'(1))) begin
			rest_q <= rest_nxt;
		end
		if (cmd.mod_step && stat.mod_last) begin
			rem_q <= rem_fix;
		end
		if (cmd.check && cand_ok) begin
			chain_mem[chain_cnt_q] <= cand;
		end
		if (rd_en) begin
			rd_data_q <= chain_mem[rd_addr];
		end
		if (cmd.load_cur || take_next) begin
			cur_q <= rd_data_q;
		end
		if (cmd.emit) begin
			owner_mem[cur_q] <= tag_q;
			link_mem[cur_q]  <= stat.emit_last ? '1 : {1'b0, rd_data_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.fail) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			block_index_q <= cur_w[BLK_W-1:0];
			next_index_q  <= stat.emit_last ? NONE_LINK : nxt_w[NEXT_W-1:0];
			failed_q      <= 1'b0;
			last_q        <= stat.emit_last;
		end else if (cmd.fail) begin
			block_index_q <= '0;
			next_index_q  <= NONE_LINK;
			failed_q      <= 1'b1;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign block_index = block_index_q;
	assign next_index  = next_index_q;
	assign failed      = failed_q;
	assign last        = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.fail) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_commit_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !alloc_q[cur_q])
		else $error("block committed twice");

	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("generator locked at zero");

endmodule
